[src/led_driver_two_wire_master_unit_defines.svh]
// ----------------------------------------------------------------------------
// led driver two-wire master assertion macros
// shared concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LED_DRIVER_TWO_WIRE_MASTER_UNIT_DEFINES_SVH
`define LED_DRIVER_TWO_WIRE_MASTER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define LEDTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LEDTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LEDTW_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define LEDTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/ledtw_pkg.sv]
// ----------------------------------------------------------------------------
// ledtw_pkg
// types, codes and constants of the two-wire led driver master
// ----------------------------------------------------------------------------
`default_nettype none

package ledtw_pkg;

   // digit geometry
   localparam int DIGIT_COUNT = 6;
   localparam int DIGIT_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int FRAME_W     = $clog2(DIGIT_COUNT + 2);
   localparam int ALL_SEG_W   = 48;

   // command codes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_DIGIT = 3'd1;
   localparam logic [2:0] OP_ALL   = 3'd2;
   localparam logic [2:0] OP_CTRL  = 3'd3;
   localparam logic [2:0] OP_KEY   = 3'd4;

   // register addresses
   localparam logic [1:0] CSR_BRIGHTNESS  = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_ON  = 2'd1;
   localparam logic [1:0] CSR_DELAY_TICKS = 2'd2;

   // protocol bytes
   localparam logic [7:0] CMD_DATA_FIXED   = 8'h44;
   localparam logic [7:0] CMD_READ_KEY     = 8'h42;
   localparam logic [7:0] CMD_ADDR_BASE    = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY_BASE = 8'h80;
   localparam logic [7:0] CMD_ENABLE_BIT   = 8'h08;
   localparam logic [2:0] BRIGHT_MAX       = 3'd7;

   // reset values of the registers
   localparam logic [2:0] BRIGHT_RESET = 3'd4;
   localparam logic [7:0] DELAY_RESET  = 8'd3;

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LO, PH_BIT_HI, PH_ACK_LO,
      PH_ACK_HI, PH_KEY_LO, PH_KEY_HI, PH_KTAIL_A, PH_KTAIL_B,
      PH_STOP_A, PH_STOP_B, PH_STOP_C
   } phase_type;

   typedef struct packed {
      logic [2:0] brightness;
      logic       display_on;
      logic [7:0] delay_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0]           command;
      logic [2:0]           position;
      logic [7:0]           segments;
      logic [ALL_SEG_W-1:0] all_segments;
      logic                 dio_in;
   } req_type;

   typedef struct packed {
      logic       clk_out;
      logic       dio_out;
      logic       busy_res;
      logic       key_valid;
      logic [7:0] key_code;
      logic       nack_seen;
   } rsp_type;

endpackage

`default_nettype wire

[src/ledtw_channels.sv]
// ----------------------------------------------------------------------------
// ledtw channels
// valid/ready interfaces for tick, result and register write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface ledtw_req_if;
   import ledtw_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [2:0]           command;
   logic [2:0]           position;
   logic [7:0]           segments;
   logic [ALL_SEG_W-1:0] all_segments;
   logic                 dio_in;
   modport source (output valid, command, position, segments, all_segments, dio_in,
                   input ready);
   modport sink (input valid, command, position, segments, all_segments, dio_in,
                 output ready);
endinterface

interface ledtw_rsp_if;
   logic       valid;
   logic       ready;
   logic       clk_out;
   logic       dio_out;
   logic       busy_res;
   logic       key_valid;
   logic [7:0] key_code;
   logic       nack_seen;
   modport source (output valid, clk_out, dio_out, busy_res, key_valid, key_code,
                   nack_seen, input ready);
   modport sink (input valid, clk_out, dio_out, busy_res, key_valid, key_code,
                 nack_seen, output ready);
endinterface

interface ledtw_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] addr;
   logic [7:0] wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

[src/led_driver_two_wire_master_unit.sv]
// ----------------------------------------------------------------------------
// led_driver_two_wire_master_unit
// two-wire led driver serial master, one pin tick per input transfer
// ----------------------------------------------------------------------------
//  channel  dir  contents
//  req_ch   in   command, position, segments, all_segments, dio_in
//  rsp_ch   out  clk_out, dio_out, busy_res, key_valid, key_code, nack_seen
//  csr_ch   in   addr (0 brightness, 1 display_on, 2 delay_ticks), wdata
//
//  one tick transfer per cycle; its result is registered and shows next cycle
//  the result register frees on the same edge it is taken, so no bubble
//  a stalled result channel holds off req_ch.ready; csr_ch is always ready
//  synchronous reset: idle, pins released, registers 4 / 1 / 3
// ----------------------------------------------------------------------------
`default_nettype none

module led_driver_two_wire_master_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   ledtw_req_if.sink   req_ch,
   ledtw_rsp_if.source rsp_ch,
   ledtw_csr_if.sink   csr_ch
);
   import ledtw_pkg::*;

   cfg_type cfg;
   req_type req;
   rsp_type seq_rsp;
   rsp_type out_rsp;
   logic    accept;
   logic    room;
   logic    out_valid;

   // register writes
   assign csr_ch.ready = 1'b1;

   ledtw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_ch.valid),
      .wr_addr (csr_ch.addr),
      .wr_data (csr_ch.wdata),
      .cfg     (cfg)
   );

   // tick transfer
   assign req_ch.ready     = room;
   assign accept           = req_ch.valid && room;
   assign req.command      = req_ch.command;
   assign req.position     = req_ch.position;
   assign req.segments     = req_ch.segments;
   assign req.all_segments = req_ch.all_segments;
   assign req.dio_in       = req_ch.dio_in;

   ledtw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .cfg    (cfg),
      .rsp    (seq_rsp)
   );

   ledtw_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .data_in  (seq_rsp),
      .take     (rsp_ch.ready),
      .room     (room),
      .valid    (out_valid),
      .data_out (out_rsp)
   );

   // result channel
   assign rsp_ch.valid     = out_valid;
   assign rsp_ch.clk_out   = out_rsp.clk_out;
   assign rsp_ch.dio_out   = out_rsp.dio_out;
   assign rsp_ch.busy_res  = out_rsp.busy_res;
   assign rsp_ch.key_valid = out_rsp.key_valid;
   assign rsp_ch.key_code  = out_rsp.key_code;
   assign rsp_ch.nack_seen = out_rsp.nack_seen;

endmodule

`default_nettype wire

[src/ledtw_csr.sv]
// ----------------------------------------------------------------------------
// ledtw_csr
// brightness, display enable and delay registers with write decode
// ----------------------------------------------------------------------------
`default_nettype none

module ledtw_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [1:0]        wr_addr,
   input  wire logic [7:0]        wr_data,
   output ledtw_pkg::cfg_type     cfg
);
   import ledtw_pkg::*;

   logic [2:0] brightness_ff, brightness_in;
   logic       display_on_ff, display_on_in;
   logic [7:0] delay_ff, delay_in;

   // write decode, brightness saturates
   always_comb begin
      brightness_in = brightness_ff;
      display_on_in = display_on_ff;
      delay_in      = delay_ff;
      if (wr_en) begin
         unique case (wr_addr)
            CSR_BRIGHTNESS: begin
               brightness_in = (wr_data > 8'(BRIGHT_MAX)) ? BRIGHT_MAX : wr_data[2:0];
            end
            CSR_DISPLAY_ON: begin
               display_on_in = wr_data[0];
            end
            CSR_DELAY_TICKS: begin
               delay_in = wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHT_RESET;
         display_on_ff <= 1'b1;
         delay_ff      <= DELAY_RESET;
      end else begin
         brightness_ff <= brightness_in;
         display_on_ff <= display_on_in;
         delay_ff      <= delay_in;
      end
   end

   assign cfg.brightness  = brightness_ff;
   assign cfg.display_on  = display_on_ff;
   assign cfg.delay_ticks = delay_ff;

endmodule

`default_nettype wire

[src/ledtw_seq.sv]
// ----------------------------------------------------------------------------
// ledtw_seq
// pin sequencer: one tick per accepted item, frames, bytes and key read
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_driver_two_wire_master_unit_defines.svh"

module ledtw_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  ledtw_pkg::req_type     req,
   input  ledtw_pkg::cfg_type     cfg,
   output ledtw_pkg::rsp_type     rsp
);
   import ledtw_pkg::*;

   // sequencer state
   phase_type          phase_ff, phase_in;
   logic [7:0]         delay_ff, delay_in;
   logic [3:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [2:0]         op_ff, op_in;
   logic [DIGIT_W-1:0] target_ff, target_in;
   logic               sel_ff, sel_in;
   logic [7:0]         key_shift_ff, key_shift_in;
   logic [7:0]         key_last_ff, key_last_in;
   logic [7:0]         store_ff [DIGIT_COUNT];

   // working values of this tick
   logic               start;
   phase_type          ph;
   logic [7:0]         dc;
   logic [7:0]         dc_inc;
   logic [7:0]         dmax;
   logic [FRAME_W-1:0] fi;
   logic [2:0]         op;
   logic [FRAME_W-1:0] last_frame;
   logic               two_bytes;
   logic               load_sel;
   logic [DIGIT_W-1:0] digit;
   logic [7:0]         ctrl_byte;
   logic [7:0]         load_byte;
   logic [3:0]         bit_next;
   logic               kvalid;
   logic               nack;

   // command start, only from idle
   always_comb begin
      start = 1'b0;
      if (phase_ff == PH_IDLE) begin
         unique case (req.command)
            OP_DIGIT: start = (req.position < 3'(DIGIT_COUNT));
            OP_ALL, OP_CTRL, OP_KEY: start = 1'b1;
            default: start = 1'b0;
         endcase
      end
      ph        = start ? PH_START_A : phase_ff;
      dc        = start ? 8'd0 : delay_ff;
      fi        = start ? '0 : frame_ff;
      op        = start ? req.command : op_ff;
      target_in = (start && req.command == OP_DIGIT) ? req.position[DIGIT_W-1:0]
                                                     : target_ff;
      dmax      = (cfg.delay_ticks == 8'd0) ? 8'd1 : cfg.delay_ticks;
      dc_inc    = dc + 8'd1;
   end

   // frame layout and the byte to load next
   always_comb begin
      last_frame = '0;
      if (op == OP_DIGIT) begin
         last_frame = FRAME_W'(2);
      end else if (op == OP_ALL) begin
         last_frame = FRAME_W'(DIGIT_COUNT + 1);
      end
      two_bytes = (op == OP_DIGIT || op == OP_ALL) && fi != '0 && fi != last_frame;
      ctrl_byte = CMD_DISPLAY_BASE | (cfg.display_on ? CMD_ENABLE_BIT : 8'd0)
                | {5'd0, cfg.brightness};
      load_sel  = (ph != PH_START_B);
      digit     = (op == OP_DIGIT) ? target_in : fi[DIGIT_W-1:0] - DIGIT_W'(1);
      if ({1'b0, digit} >= (DIGIT_W + 1)'(DIGIT_COUNT)) begin
         digit = '0;
      end
      if (op == OP_KEY) begin
         load_byte = CMD_READ_KEY;
      end else if (op == OP_CTRL || fi == last_frame) begin
         load_byte = ctrl_byte;
      end else if (fi == '0) begin
         load_byte = CMD_DATA_FIXED;
      end else if (!load_sel) begin
         load_byte = CMD_ADDR_BASE + 8'(digit);
      end else begin
         load_byte = store_ff[digit];
      end
   end

   // next state
   always_comb begin
      phase_in     = ph;
      delay_in     = dc;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      frame_in     = fi;
      op_in        = op;
      sel_in       = sel_ff;
      key_shift_in = key_shift_ff;
      key_last_in  = key_last_ff;
      kvalid       = 1'b0;
      nack         = 1'b0;
      bit_next     = bit_ff + 4'd1;
      if (ph != PH_IDLE) begin
         if (dc_inc >= dmax) begin
            delay_in = 8'd0;
            unique case (ph)
               PH_START_A: phase_in = PH_START_B;
               PH_START_B: begin
                  sel_in   = 1'b0;
                  shift_in = load_byte;
                  bit_in   = 4'd0;
                  phase_in = PH_BIT_LO;
               end
               PH_BIT_LO: phase_in = PH_BIT_HI;
               PH_BIT_HI: begin
                  shift_in = {1'b0, shift_ff[7:1]};
                  bit_in   = bit_next;
                  phase_in = (bit_next >= 4'd8) ? PH_ACK_LO : PH_BIT_LO;
               end
               PH_ACK_LO: phase_in = PH_ACK_HI;
               PH_ACK_HI: begin
                  nack = req.dio_in;
                  if (op == OP_KEY) begin
                     key_shift_in = 8'd0;
                     bit_in       = 4'd0;
                     phase_in     = PH_KEY_LO;
                  end else if (!sel_ff && two_bytes) begin
                     sel_in   = 1'b1;
                     shift_in = load_byte;
                     bit_in   = 4'd0;
                     phase_in = PH_BIT_LO;
                  end else begin
                     phase_in = PH_STOP_A;
                  end
               end
               PH_KEY_LO: phase_in = PH_KEY_HI;
               PH_KEY_HI: begin
                  key_shift_in = {req.dio_in, key_shift_ff[7:1]};
                  bit_in       = bit_next;
                  phase_in     = (bit_next >= 4'd8) ? PH_KTAIL_A : PH_KEY_LO;
               end
               PH_KTAIL_A: phase_in = PH_KTAIL_B;
               PH_KTAIL_B: phase_in = PH_STOP_A;
               PH_STOP_A:  phase_in = PH_STOP_B;
               PH_STOP_B:  phase_in = PH_STOP_C;
               default: begin
                  if (fi < last_frame) begin
                     frame_in = fi + FRAME_W'(1);
                     phase_in = PH_START_A;
                  end else begin
                     if (op == OP_KEY) begin
                        key_last_in = key_shift_ff;
                        kvalid      = 1'b1;
                     end
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end else begin
            delay_in = dc_inc;
         end
      end
   end

   // pin levels and result of this tick
   always_comb begin
      rsp.busy_res  = (ph != PH_IDLE);
      rsp.key_valid = kvalid;
      rsp.key_code  = key_last_in;
      rsp.nack_seen = nack;
      unique case (ph)
         PH_START_B, PH_STOP_B, PH_KTAIL_B: begin
            rsp.clk_out = 1'b1;
            rsp.dio_out = 1'b0;
         end
         PH_BIT_LO: begin
            rsp.clk_out = 1'b0;
            rsp.dio_out = shift_ff[0];
         end
         PH_BIT_HI: begin
            rsp.clk_out = 1'b1;
            rsp.dio_out = shift_ff[0];
         end
         PH_ACK_LO, PH_KEY_LO: begin
            rsp.clk_out = 1'b0;
            rsp.dio_out = 1'b1;
         end
         PH_KTAIL_A, PH_STOP_A: begin
            rsp.clk_out = 1'b0;
            rsp.dio_out = 1'b0;
         end
         default: begin
            rsp.clk_out = 1'b1;
            rsp.dio_out = 1'b1;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         delay_ff     <= 8'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         frame_ff     <= '0;
         op_ff        <= OP_TICK;
         target_ff    <= '0;
         sel_ff       <= 1'b0;
         key_shift_ff <= 8'd0;
         key_last_ff  <= 8'd0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         delay_ff     <= delay_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         frame_ff     <= frame_in;
         op_ff        <= op_in;
         target_ff    <= target_in;
         sel_ff       <= sel_in;
         key_shift_ff <= key_shift_in;
         key_last_ff  <= key_last_in;
      end
   end

   // digit store, written when a digit or all-digits command starts
   always_ff @(posedge clock) begin
      if (accept && start) begin
         if (req.command == OP_ALL) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               store_ff[i] <= req.all_segments[8*i +: 8];
            end
         end else if (req.command == OP_DIGIT) begin
            store_ff[req.position[DIGIT_W-1:0]] <= req.segments;
         end
      end
   end

   `LEDTW_ASSERT_NOW(a_idle_pins_released, clock, reset, !rsp.busy_res,
      rsp.clk_out && rsp.dio_out, "pins not released while idle")
   `LEDTW_ASSERT_NEXT(a_key_done_idle, clock, reset, accept && rsp.key_valid,
      phase_ff == PH_IDLE, "key read finished but sequencer not idle")
   `LEDTW_ASSERT_NOW(a_bit_range, clock, reset, phase_ff != PH_IDLE,
      bit_ff <= 4'd8, "bit counter beyond a byte")

endmodule

`default_nettype wire

[src/ledtw_rsp_reg.sv]
// ----------------------------------------------------------------------------
// ledtw_rsp_reg
// result register between the sequencer and the result channel
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_driver_two_wire_master_unit_defines.svh"

module ledtw_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  ledtw_pkg::rsp_type     data_in,
   input  wire logic              take,
   output wire logic              room,
   output wire logic              valid,
   output ledtw_pkg::rsp_type     data_out
);
   import ledtw_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // full slot frees when taken, refills on a new transfer
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign room     = !valid_ff || take;
   assign valid    = valid_ff;
   assign data_out = data_ff;

   `LEDTW_ASSERT_NEXT(a_load_shows, clock, reset, load, valid_ff,
      "loaded result not presented")

endmodule

`default_nettype wire
